/* hw/rtl/jsm_pkg.sv */
package jsm_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BUTTON  = 2'd0;
  localparam logic [1:0] KIND_AXIS    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // Decoded operations handed from front to back
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_LIN_UP   = 3'd1;
  localparam logic [2:0] OP_LIN_DN   = 3'd2;
  localparam logic [2:0] OP_ANG_UP   = 3'd3;
  localparam logic [2:0] OP_ANG_DN   = 3'd4;
  localparam logic [2:0] OP_AXIS_LIN = 3'd5;
  localparam logic [2:0] OP_AXIS_ANG = 3'd6;

  // Event type codes (init flag stripped)
  localparam logic [6:0] TYPE_BUTTON = 7'h01;
  localparam logic [6:0] TYPE_AXIS   = 7'h02;

  // Control numbers
  localparam logic [7:0] BTN_LIN_UP = 8'd4;
  localparam logic [7:0] BTN_LIN_DN = 8'd0;
  localparam logic [7:0] BTN_ANG_UP = 8'd3;
  localparam logic [7:0] BTN_ANG_DN = 8'd1;
  localparam logic [7:0] AXIS_LIN   = 8'd1;
  localparam logic [7:0] AXIS_ANG   = 8'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_DEAD_ZONE    = 3'd0;
  localparam logic [2:0] REG_AXIS_GAIN    = 3'd1;
  localparam logic [2:0] REG_LINEAR_STEP  = 3'd2;
  localparam logic [2:0] REG_LINEAR_MIN   = 3'd3;
  localparam logic [2:0] REG_LINEAR_MAX   = 3'd4;
  localparam logic [2:0] REG_ANGULAR_STEP = 3'd5;
  localparam logic [2:0] REG_ANGULAR_MIN  = 3'd6;
  localparam logic [2:0] REG_ANGULAR_MAX  = 3'd7;

  // Reset values
  localparam logic [14:0] RST_DEAD_ZONE    = 15'd1638;
  localparam logic [15:0] RST_AXIS_GAIN    = 16'd34492;
  localparam logic [15:0] RST_LINEAR_STEP  = 16'd25;
  localparam logic [15:0] RST_LINEAR_MIN   = 16'd0;
  localparam logic [15:0] RST_LINEAR_MAX   = 16'd32767;
  localparam logic [15:0] RST_ANGULAR_STEP = 16'd25;
  localparam logic [15:0] RST_ANGULAR_MIN  = 16'd0;
  localparam logic [15:0] RST_ANGULAR_MAX  = 16'd32767;
  localparam logic [15:0] DEFAULT_SCALE    = 16'd16384;

  // Command queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [15:0] axis_gain;
    logic [15:0] linear_step;
    logic [15:0] linear_min;
    logic [15:0] linear_max;
    logic [15:0] angular_step;
    logic [15:0] angular_min;
    logic [15:0] angular_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  op;
    logic [15:0] adj;   // deadzone-adjusted axis value, two's complement
  } cmd_t;

  // x / 2^15 rounded to nearest (ties away from zero), saturated to 17 bits signed
  function automatic logic signed [16:0] round_sat(input logic signed [33:0] x);
    logic        neg;
    logic [33:0] mag;
    logic [34:0] sum;
    logic [19:0] r;
    logic [16:0] v;
    neg = x[33];
    mag = x;
    if (neg) begin
      mag = ~mag + 34'd1;
    end
    sum = {1'b0, mag} + 35'd16384;
    r   = sum[34:15];
    if (neg) begin
      if (r > 20'd65536) begin
        v = 17'h10000;
      end else begin
        v = ~r[16:0] + 17'd1;
      end
    end else begin
      if (r > 20'd65535) begin
        v = 17'h0FFFF;
      end else begin
        v = r[16:0];
      end
    end
    return $signed(v);
  endfunction

endpackage

/* hw/rtl/joystick_speed_mapper_top.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_event_type, in_control_number, in_event_value
// out      out_valid / out_ready  out_event_kind, out_linear_speed, out_turn_speed,
//                                 out_linear_scale_now, out_angular_scale_now
// cfg      cfg_wr_en              cfg_index, cfg_data
//
// Button, unmapped-axis and ignored beats finish in the back end's idle state; axis 1 and 3
// beats step through issue, multiply, round, multiply, round on the one shared 17x17 multiplier.
// out_valid is set from the idle state for buttons and from the last round state for mapped axes.
// A 2-entry command queue lets the input side keep accepting while the back end works
// or the result register waits on out_ready.
// Reset (rst_n, synchronous) empties the queue and restores scales and registers.
module joystick_speed_mapper_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_event_type,
  input  logic [7:0]         in_control_number,
  input  logic signed [15:0] in_event_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_kind,
  output logic signed [16:0] out_linear_speed,
  output logic signed [16:0] out_turn_speed,
  output logic [15:0]        out_linear_scale_now,
  output logic [15:0]        out_angular_scale_now,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  jsm_pkg::cfg_t cfg_r, cfg_nxt;
  jsm_pkg::cmd_t front_cmd;
  jsm_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        jsm_pkg::REG_DEAD_ZONE:    cfg_nxt.dead_zone    = cfg_data[14:0];
        jsm_pkg::REG_AXIS_GAIN:    cfg_nxt.axis_gain    = cfg_data;
        jsm_pkg::REG_LINEAR_STEP:  cfg_nxt.linear_step  = cfg_data;
        jsm_pkg::REG_LINEAR_MIN:   cfg_nxt.linear_min   = cfg_data;
        jsm_pkg::REG_LINEAR_MAX:   cfg_nxt.linear_max   = cfg_data;
        jsm_pkg::REG_ANGULAR_STEP: cfg_nxt.angular_step = cfg_data;
        jsm_pkg::REG_ANGULAR_MIN:  cfg_nxt.angular_min  = cfg_data;
        jsm_pkg::REG_ANGULAR_MAX:  cfg_nxt.angular_max  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone    <= jsm_pkg::RST_DEAD_ZONE;
      cfg_r.axis_gain    <= jsm_pkg::RST_AXIS_GAIN;
      cfg_r.linear_step  <= jsm_pkg::RST_LINEAR_STEP;
      cfg_r.linear_min   <= jsm_pkg::RST_LINEAR_MIN;
      cfg_r.linear_max   <= jsm_pkg::RST_LINEAR_MAX;
      cfg_r.angular_step <= jsm_pkg::RST_ANGULAR_STEP;
      cfg_r.angular_min  <= jsm_pkg::RST_ANGULAR_MIN;
      cfg_r.angular_max  <= jsm_pkg::RST_ANGULAR_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jsm_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_event_type     (in_event_type),
    .in_control_number (in_control_number),
    .in_event_value    (in_event_value),
    .dead_zone         (cfg_r.dead_zone),
    .q_full            (q_full),
    .push              (push),
    .cmd               (front_cmd)
  );

  jsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .cmd_out (head_cmd)
  );

  jsm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_empty               (q_empty),
    .cmd                   (head_cmd),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_event_kind        (out_event_kind),
    .out_linear_speed      (out_linear_speed),
    .out_turn_speed        (out_turn_speed),
    .out_linear_scale_now  (out_linear_scale_now),
    .out_angular_scale_now (out_angular_scale_now)
  );

endmodule

/* hw/rtl/jsm_front.sv */
// Front end: takes input beats, classifies them and applies the deadzone
module jsm_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_event_type,
  input  logic [7:0]         in_control_number,
  input  logic signed [15:0] in_event_value,
  input  logic [14:0]        dead_zone,
  input  logic               q_full,
  output logic               push,
  output jsm_pkg::cmd_t      cmd
);

  logic [6:0]         base;
  logic signed [16:0] val17;
  logic signed [16:0] dz17;
  logic signed [16:0] adj17;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign base     = in_event_type[6:0];
  assign val17    = {in_event_value[15], in_event_value};
  assign dz17     = $signed({2'b00, dead_zone});

  // Symmetric deadzone
  always_comb begin
    if (val17 > dz17) begin
      adj17 = val17 - dz17;
    end else if (val17 < -dz17) begin
      adj17 = val17 + dz17;
    end else begin
      adj17 = 17'sd0;
    end
  end

  // Event decode
  always_comb begin
    cmd.kind = jsm_pkg::KIND_IGNORED;
    cmd.op   = jsm_pkg::OP_NONE;
    cmd.adj  = adj17[15:0];
    if (base == jsm_pkg::TYPE_BUTTON) begin
      cmd.kind = jsm_pkg::KIND_BUTTON;
      if (in_event_value == 16'sd1) begin
        case (in_control_number)
          jsm_pkg::BTN_LIN_UP: cmd.op = jsm_pkg::OP_LIN_UP;
          jsm_pkg::BTN_LIN_DN: cmd.op = jsm_pkg::OP_LIN_DN;
          jsm_pkg::BTN_ANG_UP: cmd.op = jsm_pkg::OP_ANG_UP;
          jsm_pkg::BTN_ANG_DN: cmd.op = jsm_pkg::OP_ANG_DN;
          default:             cmd.op = jsm_pkg::OP_NONE;
        endcase
      end
    end else if (base == jsm_pkg::TYPE_AXIS) begin
      cmd.kind = jsm_pkg::KIND_AXIS;
      case (in_control_number)
        jsm_pkg::AXIS_LIN: cmd.op = jsm_pkg::OP_AXIS_LIN;
        jsm_pkg::AXIS_ANG: cmd.op = jsm_pkg::OP_AXIS_ANG;
        default:           cmd.op = jsm_pkg::OP_NONE;
      endcase
    end
  end

endmodule

/* hw/rtl/jsm_queue.sv */
// Short command queue between front and back
module jsm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsm_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output jsm_pkg::cmd_t cmd_out
);

  localparam logic [jsm_pkg::QPTR_W-1:0] PTR_LAST = jsm_pkg::QPTR_W'(jsm_pkg::QUEUE_DEPTH - 1);
  localparam logic [jsm_pkg::QCNT_W-1:0] CNT_FULL = jsm_pkg::QCNT_W'(jsm_pkg::QUEUE_DEPTH);

  jsm_pkg::cmd_t               mem_r [jsm_pkg::QUEUE_DEPTH];
  logic [jsm_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [jsm_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [jsm_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign cmd_out = mem_r[rd_ptr_r];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* hw/rtl/jsm_back.sv */
// Back end: scale stepping, shared multiplier sequencer and result register
module jsm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsm_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  jsm_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_kind,
  output logic signed [16:0] out_linear_speed,
  output logic signed [16:0] out_turn_speed,
  output logic [15:0]        out_linear_scale_now,
  output logic [15:0]        out_angular_scale_now
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_RND1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_RND2 = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic signed [16:0] mul_a_r, mul_a_nxt;
  logic signed [16:0] mul_b_r, mul_b_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic               axis_ang_r, axis_ang_nxt;
  logic [15:0]        lin_scale_r, lin_scale_nxt;
  logic [15:0]        ang_scale_r, ang_scale_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic signed [16:0] out_lin_r, out_lin_nxt;
  logic signed [16:0] out_ang_r, out_ang_nxt;
  logic [15:0]        out_lin_scale_r, out_lin_scale_nxt;
  logic [15:0]        out_ang_scale_r, out_ang_scale_nxt;

  logic               out_free;
  logic signed [33:0] prod;
  logic signed [16:0] defl;
  logic signed [16:0] speed;
  logic [15:0]        lin_up, lin_dn, ang_up, ang_dn;

  function automatic logic [15:0] step_up(input logic [15:0] s, input logic [15:0] inc,
                                          input logic [15:0] hi);
    logic [16:0] sum;
    sum = {1'b0, s} + {1'b0, inc};
    return (sum > {1'b0, hi}) ? hi : sum[15:0];
  endfunction

  function automatic logic [15:0] step_down(input logic [15:0] s, input logic [15:0] dec,
                                            input logic [15:0] lo);
    logic signed [17:0] diff;
    diff = $signed({2'b00, s}) - $signed({2'b00, dec});
    return (diff < $signed({2'b00, lo})) ? lo : diff[15:0];
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign prod     = mul_a_r * mul_b_r;
  assign defl     = jsm_pkg::round_sat(-prod_r);
  assign speed    = jsm_pkg::round_sat(prod_r);
  assign lin_up   = step_up(lin_scale_r, cfg.linear_step, cfg.linear_max);
  assign lin_dn   = step_down(lin_scale_r, cfg.linear_step, cfg.linear_min);
  assign ang_up   = step_up(ang_scale_r, cfg.angular_step, cfg.angular_max);
  assign ang_dn   = step_down(ang_scale_r, cfg.angular_step, cfg.angular_min);

  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    mul_a_nxt         = mul_a_r;
    mul_b_nxt         = mul_b_r;
    prod_nxt          = prod_r;
    axis_ang_nxt      = axis_ang_r;
    lin_scale_nxt     = lin_scale_r;
    ang_scale_nxt     = ang_scale_r;
    out_valid_nxt     = out_valid_r;
    out_kind_nxt      = out_kind_r;
    out_lin_nxt       = out_lin_r;
    out_ang_nxt       = out_ang_r;
    out_lin_scale_nxt = out_lin_scale_r;
    out_ang_scale_nxt = out_ang_scale_r;
    pop               = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          if (cmd.op == jsm_pkg::OP_AXIS_LIN || cmd.op == jsm_pkg::OP_AXIS_ANG) begin
            // deflection = -(adj * gain) first
            mul_a_nxt    = $signed({cmd.adj[15], cmd.adj});
            mul_b_nxt    = $signed({1'b0, cfg.axis_gain});
            axis_ang_nxt = (cmd.op == jsm_pkg::OP_AXIS_ANG);
            state_nxt    = ST_MUL1;
          end else begin
            // buttons, unmapped axes and ignored types finish here
            case (cmd.op)
              jsm_pkg::OP_LIN_UP: lin_scale_nxt = lin_up;
              jsm_pkg::OP_LIN_DN: lin_scale_nxt = lin_dn;
              jsm_pkg::OP_ANG_UP: ang_scale_nxt = ang_up;
              jsm_pkg::OP_ANG_DN: ang_scale_nxt = ang_dn;
              default: ;
            endcase
            out_valid_nxt     = 1'b1;
            out_kind_nxt      = cmd.kind;
            out_lin_nxt       = 17'sd0;
            out_ang_nxt       = 17'sd0;
            out_lin_scale_nxt = lin_scale_nxt;
            out_ang_scale_nxt = ang_scale_nxt;
          end
        end
      end
      ST_MUL1: begin
        prod_nxt  = prod;
        state_nxt = ST_RND1;
      end
      ST_RND1: begin
        // speed = deflection * scale next
        mul_a_nxt = defl;
        mul_b_nxt = $signed({1'b0, axis_ang_r ? ang_scale_r : lin_scale_r});
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = prod;
        state_nxt = ST_RND2;
      end
      ST_RND2: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_kind_nxt      = jsm_pkg::KIND_AXIS;
          out_lin_nxt       = axis_ang_r ? 17'sd0 : speed;
          out_ang_nxt       = axis_ang_r ? speed : 17'sd0;
          out_lin_scale_nxt = lin_scale_r;
          out_ang_scale_nxt = ang_scale_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lin_scale_r <= jsm_pkg::DEFAULT_SCALE;
      ang_scale_r <= jsm_pkg::DEFAULT_SCALE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lin_scale_r <= lin_scale_nxt;
      ang_scale_r <= ang_scale_nxt;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    mul_a_r         <= mul_a_nxt;
    mul_b_r         <= mul_b_nxt;
    prod_r          <= prod_nxt;
    axis_ang_r      <= axis_ang_nxt;
    out_kind_r      <= out_kind_nxt;
    out_lin_r       <= out_lin_nxt;
    out_ang_r       <= out_ang_nxt;
    out_lin_scale_r <= out_lin_scale_nxt;
    out_ang_scale_r <= out_ang_scale_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_event_kind        = out_kind_r;
  assign out_linear_speed      = out_lin_r;
  assign out_turn_speed        = out_ang_r;
  assign out_linear_scale_now  = out_lin_scale_r;
  assign out_angular_scale_now = out_ang_scale_r;

endmodule
